### rtl/glcdf_pkg.sv
// ----------------------------------------------------------------------------
// Graphic LCD frame-store flusher: shared package
// Types, constants and helper functions used by the front end, the command
// queue and the back end of the flusher.
// ----------------------------------------------------------------------------
`default_nettype none

package glcdf_pkg;

    // Display geometry.
    localparam int COLUMNS             = 128;
    localparam int SCREEN_ROWS_DEFAULT = 64;

    // Depth of the queue between front end and back end.
    localparam int QUEUE_DEPTH = 4;

    // Input mode codes.
    localparam logic [2:0] MODE_PIXEL = 3'd0;
    localparam logic [2:0] MODE_CLEAR = 3'd1;
    localparam logic [2:0] MODE_INIT  = 3'd2;
    localparam logic [2:0] MODE_FLUSH = 3'd3;
    localparam logic [2:0] MODE_TICK  = 3'd4;

    // Display command bases.
    localparam logic [7:0] CMD_COLUMN_BASE = 8'h40;
    localparam logic [7:0] CMD_PAGE_BASE   = 8'hB8;

    // Chip selects.
    localparam logic [1:0] HALF_LEFT  = 2'd1;
    localparam logic [1:0] HALF_RIGHT = 2'd2;

    // Classified command carried through the queue.
    typedef enum logic [2:0] {
        CMD_PIXEL,
        CMD_CLEAR,
        CMD_INIT,
        CMD_FLUSH,
        CMD_TICK
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [9:0] store_addr;  // {page, column} of a pixel
        logic [2:0] bit_sel;     // row within the page
        logic       busy;        // sampled busy flag of a tick
    } q_entry_t;

    // The four control words of the init sequence, in order.
    function automatic logic [7:0] control_word(input logic [1:0] sel);
        logic [7:0] w;
        unique case (sel)
            2'd0:    w = 8'h40;
            2'd1:    w = 8'hB8;
            2'd2:    w = 8'hFF;
            default: w = 8'h3F;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/glcdf_queue.sv
// ----------------------------------------------------------------------------
// Graphic LCD flusher: command queue
// Short FIFO of classified commands between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module glcdf_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire glcdf_pkg::q_entry_t push_entry,
    input  wire logic                pop,
    output glcdf_pkg::q_entry_t      head,
    output logic                     empty,
    output logic                     full
);

    localparam int PTR_W = $clog2(glcdf_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(glcdf_pkg::QUEUE_DEPTH + 1);

    glcdf_pkg::q_entry_t entries_reg [glcdf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(glcdf_pkg::QUEUE_DEPTH));
    assign head  = entries_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(glcdf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                               : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(glcdf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                               : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

### rtl/glcdf_front.sv
// ----------------------------------------------------------------------------
// Graphic LCD flusher: front end
// Accepts input items, drops unused modes and out-of-range pixels, and
// queues the rest as classified commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module glcdf_front #(
    parameter int SCREEN_ROWS = glcdf_pkg::SCREEN_ROWS_DEFAULT
) (
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         mode,
    input  wire logic signed [8:0]  pixel_x,
    input  wire logic signed [7:0]  pixel_y,
    input  wire logic               busy_flag,
    input  wire logic               q_full,
    input  wire logic               sweep_busy,
    output logic                    push,
    output glcdf_pkg::q_entry_t     push_entry
);

    localparam logic [8:0] ROW_LIMIT = 9'(SCREEN_ROWS);

    logic accept;
    logic pixel_ok;
    logic keep;

    // Hold off while the queue is full or the store is swept after reset.
    assign in_stall = q_full || sweep_busy;
    assign accept   = in_valid && !in_stall;

    // Negative coordinates have their top bits set and so fail both checks.
    assign pixel_ok = (pixel_x[8:7] == 2'b00) && ({1'b0, pixel_y} < ROW_LIMIT);

    // Classify the item.
    always_comb
    begin
        keep                  = 1'b1;
        push_entry.cmd        = glcdf_pkg::CMD_TICK;
        push_entry.store_addr = {pixel_y[5:3], pixel_x[6:0]};
        push_entry.bit_sel    = pixel_y[2:0];
        push_entry.busy       = busy_flag;
        unique case (mode)
            glcdf_pkg::MODE_PIXEL:
            begin
                push_entry.cmd = glcdf_pkg::CMD_PIXEL;
                keep           = pixel_ok;
            end
            glcdf_pkg::MODE_CLEAR: push_entry.cmd = glcdf_pkg::CMD_CLEAR;
            glcdf_pkg::MODE_INIT:  push_entry.cmd = glcdf_pkg::CMD_INIT;
            glcdf_pkg::MODE_FLUSH: push_entry.cmd = glcdf_pkg::CMD_FLUSH;
            glcdf_pkg::MODE_TICK:  push_entry.cmd = glcdf_pkg::CMD_TICK;
            default:               keep           = 1'b0;
        endcase
    end

    assign push = accept && keep;

endmodule

`default_nettype wire

### rtl/glcdf_back.sv
// ----------------------------------------------------------------------------
// Graphic LCD flusher: back end
// Owns the frame store and the write sequencer; carries out queued commands
// in order and drives the registered result item.
// ----------------------------------------------------------------------------
`default_nettype none

module glcdf_back #(
    parameter int SCREEN_ROWS = glcdf_pkg::SCREEN_ROWS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire glcdf_pkg::q_entry_t q_head,
    input  wire logic                q_empty,
    output logic                     q_pop,
    output logic                     sweep_busy,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     bus_write,
    output logic [1:0]               chip_half,
    output logic                     register_select,
    output logic [7:0]               bus_byte,
    output logic                     sequence_last,
    output logic                     idle
);

    localparam int         PAGES       = (SCREEN_ROWS + 7) / 8;
    localparam int         STORE_DEPTH = PAGES * glcdf_pkg::COLUMNS;
    localparam int         ADDR_W      = $clog2(STORE_DEPTH);
    localparam logic [2:0] LAST_PAGE   = 3'(PAGES - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_PIXEL_WR,
        ST_DATA_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_INIT,
        SEQ_FLUSH
    } seq_t;

    // Frame store.
    logic [7:0]        store_mem [STORE_DEPTH];
    logic [7:0]        rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    // Control state.
    state_t            state_reg,     state_next;
    logic [ADDR_W-1:0] clr_addr_reg,  clr_addr_next;
    logic              sweep_reg,     sweep_next;
    seq_t              seq_reg,       seq_next;
    logic [2:0]        page_reg,      page_next;
    logic [6:0]        column_reg,    column_next;
    logic [1:0]        phase_reg,     phase_next;
    logic [2:0]        init_idx_reg,  init_idx_next;
    logic [ADDR_W-1:0] wr_addr_reg,   wr_addr_next;
    logic [7:0]        mask_reg,      mask_next;

    // Result register.
    logic              out_valid_reg, out_valid_next;
    logic              bus_write_reg, bus_write_next;
    logic [1:0]        half_reg,      half_next;
    logic              rs_reg,        rs_next;
    logic [7:0]        byte_reg,      byte_next;
    logic              last_reg,      last_next;
    logic              idle_reg,      idle_next;

    logic              out_free;
    logic [9:0]        head_addr_full;
    logic [9:0]        flush_addr_full;

    assign out_free        = !out_valid_reg || !out_stall;
    assign head_addr_full  = q_head.store_addr;
    assign flush_addr_full = {page_reg, column_reg};

    // Sequencer and store control.
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        sweep_next     = sweep_reg;
        seq_next       = seq_reg;
        page_next      = page_reg;
        column_next    = column_reg;
        phase_next     = phase_reg;
        init_idx_next  = init_idx_reg;
        wr_addr_next   = wr_addr_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg && out_stall;
        bus_write_next = bus_write_reg;
        half_next      = half_reg;
        rs_next        = rs_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        idle_next      = idle_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = wr_addr_reg;
        mem_wdata      = rd_data_reg | mask_reg;
        mem_raddr      = head_addr_full[ADDR_W-1:0];

        unique case (state_reg)
            // Zero one store entry per cycle.
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = 8'h00;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_RUN;
                    sweep_next = 1'b0;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            // Second half of a pixel read-modify-write.
            ST_PIXEL_WR:
            begin
                mem_we     = 1'b1;
                state_next = ST_RUN;
            end

            // Data byte of a flush has been read: present the result.
            ST_DATA_OUT:
            begin
                out_valid_next = 1'b1;
                byte_next      = rd_data_reg;
                state_next     = ST_RUN;
            end

            ST_RUN:
            begin
                if (!q_empty)
                begin
                    unique case (q_head.cmd)
                        glcdf_pkg::CMD_PIXEL:
                        begin
                            q_pop        = 1'b1;
                            wr_addr_next = head_addr_full[ADDR_W-1:0];
                            mask_next    = 8'h01 << q_head.bit_sel;
                            state_next   = ST_PIXEL_WR;
                        end
                        glcdf_pkg::CMD_CLEAR:
                        begin
                            q_pop         = 1'b1;
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end
                        glcdf_pkg::CMD_INIT,
                        glcdf_pkg::CMD_FLUSH:
                        begin
                            q_pop         = 1'b1;
                            seq_next      = (q_head.cmd == glcdf_pkg::CMD_INIT) ? SEQ_INIT
                                                                                 : SEQ_FLUSH;
                            page_next     = '0;
                            column_next   = '0;
                            phase_next    = '0;
                            init_idx_next = '0;
                        end
                        glcdf_pkg::CMD_TICK:
                        begin
                            if (out_free)
                            begin
                                q_pop          = 1'b1;
                                out_valid_next = 1'b1;
                                bus_write_next = 1'b0;
                                half_next      = 2'd0;
                                rs_next        = 1'b0;
                                byte_next      = 8'h00;
                                last_next      = 1'b0;
                                if (!q_head.busy && seq_reg == SEQ_INIT)
                                begin
                                    // Each control word goes left, then right.
                                    bus_write_next = 1'b1;
                                    half_next      = init_idx_reg[0] ? glcdf_pkg::HALF_RIGHT
                                                                     : glcdf_pkg::HALF_LEFT;
                                    byte_next      = glcdf_pkg::control_word(init_idx_reg[2:1]);
                                    if (init_idx_reg == 3'd7)
                                    begin
                                        last_next     = 1'b1;
                                        seq_next      = SEQ_IDLE;
                                        init_idx_next = '0;
                                    end
                                    else
                                    begin
                                        init_idx_next = init_idx_reg + 1'b1;
                                    end
                                end
                                else if (!q_head.busy && seq_reg == SEQ_FLUSH)
                                begin
                                    bus_write_next = 1'b1;
                                    half_next      = column_reg[6] ? glcdf_pkg::HALF_RIGHT
                                                                   : glcdf_pkg::HALF_LEFT;
                                    if (phase_reg == 2'd1)
                                    begin
                                        byte_next  = glcdf_pkg::CMD_PAGE_BASE | {5'd0, page_reg};
                                        phase_next = 2'd2;
                                    end
                                    else if (phase_reg == 2'd2)
                                    begin
                                        // Data byte: read the store, result follows.
                                        rs_next        = 1'b1;
                                        out_valid_next = 1'b0;
                                        mem_raddr      = flush_addr_full[ADDR_W-1:0];
                                        state_next     = ST_DATA_OUT;
                                        phase_next     = 2'd0;
                                        if (column_reg == 7'd127)
                                        begin
                                            column_next = '0;
                                            page_next   = page_reg + 1'b1;
                                            if (page_reg >= LAST_PAGE)
                                            begin
                                                last_next   = 1'b1;
                                                seq_next    = SEQ_IDLE;
                                                page_next   = '0;
                                            end
                                        end
                                        else
                                        begin
                                            column_next = column_reg + 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        byte_next  = glcdf_pkg::CMD_COLUMN_BASE
                                                   | {2'b00, column_reg[5:0]};
                                        phase_next = 2'd1;
                                    end
                                end
                                idle_next = (seq_next == SEQ_IDLE);
                            end
                        end
                        default: q_pop = 1'b1;
                    endcase
                end
            end

            default: state_next = ST_RUN;
        endcase
    end

    // State and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            sweep_reg     <= 1'b1;
            seq_reg       <= SEQ_IDLE;
            page_reg      <= '0;
            column_reg    <= '0;
            phase_reg     <= '0;
            init_idx_reg  <= '0;
            wr_addr_reg   <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
            bus_write_reg <= 1'b0;
            half_reg      <= '0;
            rs_reg        <= 1'b0;
            byte_reg      <= '0;
            last_reg      <= 1'b0;
            idle_reg      <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            sweep_reg     <= sweep_next;
            seq_reg       <= seq_next;
            page_reg      <= page_next;
            column_reg    <= column_next;
            phase_reg     <= phase_next;
            init_idx_reg  <= init_idx_next;
            wr_addr_reg   <= wr_addr_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
            bus_write_reg <= bus_write_next;
            half_reg      <= half_next;
            rs_reg        <= rs_next;
            byte_reg      <= byte_next;
            last_reg      <= last_next;
            idle_reg      <= idle_next;
        end
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= store_mem[mem_raddr];
    end

    assign sweep_busy      = sweep_reg;
    assign out_valid       = out_valid_reg;
    assign bus_write       = bus_write_reg;
    assign chip_half       = half_reg;
    assign register_select = rs_reg;
    assign bus_byte        = byte_reg;
    assign sequence_last   = last_reg;
    assign idle            = idle_reg;

endmodule

`default_nettype wire

### rtl/glcd_framebuffer_flusher.sv
// ----------------------------------------------------------------------------
// Graphic LCD frame-store flusher
// Keeps the frame store of a two-half monochrome graphic LCD and turns init
// and flush requests into a stream of bus writes, at most one per bus tick.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake             Payload
//  -------  --------------------  ---------------------------------------------
//  input    in_valid / in_stall   mode, pixel_x, pixel_y, busy_flag
//  output   out_valid / out_stall bus_write, chip_half, register_select,
//                                 bus_byte, sequence_last, idle
//
//  A flush data byte waits in the back end for the registered read of the
//  frame store, which has one write port and one registered read port.
//  A set-pixel item is a read-modify-write through those two ports.
//  A clear item sweeps the store one byte a cycle; after reset the same sweep
//  runs with in_stall high. A 4-entry queue lets the front end keep accepting
//  while out_stall holds a result back; in_stall rises only when that queue
//  is full or the reset sweep runs.
// ----------------------------------------------------------------------------
`default_nettype none

module glcd_framebuffer_flusher #(
    parameter int SCREEN_ROWS = glcdf_pkg::SCREEN_ROWS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [2:0]        mode,
    input  wire logic signed [8:0] pixel_x,
    input  wire logic signed [7:0] pixel_y,
    input  wire logic              busy_flag,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   bus_write,
    output logic [1:0]             chip_half,
    output logic                   register_select,
    output logic [7:0]             bus_byte,
    output logic                   sequence_last,
    output logic                   idle
);

    logic                push;
    glcdf_pkg::q_entry_t push_entry;
    logic                pop;
    glcdf_pkg::q_entry_t head;
    logic                q_empty;
    logic                q_full;
    logic                sweep_busy;

    // Front end: accept and classify.
    glcdf_front #(
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .busy_flag  (busy_flag),
        .q_full     (q_full),
        .sweep_busy (sweep_busy),
        .push       (push),
        .push_entry (push_entry)
    );

    // Command queue.
    glcdf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    // Back end: frame store and write sequencer.
    glcdf_back #(
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_head          (head),
        .q_empty         (q_empty),
        .q_pop           (pop),
        .sweep_busy      (sweep_busy),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .bus_write       (bus_write),
        .chip_half       (chip_half),
        .register_select (register_select),
        .bus_byte        (bus_byte),
        .sequence_last   (sequence_last),
        .idle            (idle)
    );

endmodule

`default_nettype wire

### rtl/glcdf_checker.sv
// ----------------------------------------------------------------------------
// Graphic LCD flusher: port checker
// Watches the top-level ports and flags results that break the output rules.
// ----------------------------------------------------------------------------
`default_nettype none

module glcdf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       bus_write,
    input wire logic [1:0] chip_half,
    input wire logic       register_select,
    input wire logic [7:0] bus_byte,
    input wire logic       sequence_last,
    input wire logic       idle
);

    // A held result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bus_byte) && $stable(chip_half)
                                   && $stable(register_select) && $stable(sequence_last))
        else $error("stalled result changed");

    // A tick without a write carries zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bus_write |-> chip_half == 2'd0 && !register_select
                                    && bus_byte == 8'h00 && !sequence_last)
        else $error("idle tick with non-zero fields");

    // A write selects exactly one half.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bus_write |-> chip_half == 2'd1 || chip_half == 2'd2)
        else $error("bus write without a single chip select");

    // The final write of a sequence leaves the block idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sequence_last |-> bus_write && idle)
        else $error("sequence end without idle");

endmodule

bind glcd_framebuffer_flusher glcdf_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .bus_write       (bus_write),
    .chip_half       (chip_half),
    .register_select (register_select),
    .bus_byte        (bus_byte),
    .sequence_last   (sequence_last),
    .idle            (idle)
);

`default_nettype wire
